// ===== sv/sspf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sspf_pkg;

	localparam int RANGE_W    = 16;
	localparam int ANGLE_W    = 9;
	localparam int LIMIT_W    = 16;
	localparam int HALF_W     = 8;
	localparam int FORCE_W    = 10;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int PROD_W     = LIMIT_W + FORCE_W;
	localparam int DIV_STEPS  = FORCE_W;
	localparam int STEP_W     = $clog2(DIV_STEPS);

	localparam logic [LIMIT_W-1:0] NEAR_LIMIT_RST  = 16'd500;
	localparam logic [LIMIT_W-1:0] SIDE_LIMIT_RST  = 16'd350;
	localparam logic [LIMIT_W-1:0] MIN_RANGE_RST   = 16'd0;
	localparam logic [HALF_W-1:0]  NARROW_HALF_RST = 8'd10;
	localparam logic [HALF_W-1:0]  WIDE_HALF_RST   = 8'd35;
	localparam logic [FORCE_W-1:0] FORCE_MAX_RST   = 10'd1023;

	localparam logic SIDE_FRONT = 1'b0;
	localparam logic SIDE_BACK  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NEAR_LIMIT  = 3'd0,
		CFG_SIDE_LIMIT  = 3'd1,
		CFG_MIN_RANGE   = 3'd2,
		CFG_NARROW_HALF = 3'd3,
		CFG_WIDE_HALF   = 3'd4,
		CFG_FORCE_MAX   = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_MUL,
		ST_DIV,
		ST_STORE,
		ST_LOAD
	} state_t;

	typedef struct packed {
		logic fold;
		logic setup;
		logic mul;
		logic div_step;
		logic store;
		logic load_out;
		logic side;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_status_t;

endpackage
`default_nettype wire

// ===== sv/sspf_sample_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface sspf_sample_if
	import sspf_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [RANGE_W-1:0] range_mm;
	logic [ANGLE_W-1:0] angle_index;
	logic               last_of_scan;

	modport source (output valid, output range_mm, output angle_index, output last_of_scan,
		input ready);
	modport sink (input valid, input range_mm, input angle_index, input last_of_scan,
		output ready);
endinterface
`default_nettype wire

// ===== sv/sspf_feedback_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface sspf_feedback_if
	import sspf_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               forward_rumble;
	logic [FORCE_W-1:0] forward_intensity;
	logic               backward_rumble;
	logic [FORCE_W-1:0] backward_intensity;

	modport source (output valid, output forward_rumble, output forward_intensity,
		output backward_rumble, output backward_intensity, input ready);
	modport sink (input valid, input forward_rumble, input forward_intensity,
		input backward_rumble, input backward_intensity, output ready);
endinterface
`default_nettype wire

// ===== sv/sspf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sspf_ctrl
	import sspf_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        sample_valid,
	input  wire        sample_last,
	input  dp_status_t status,
	output logic       sample_ready,
	output dp_cmd_t    cmd
);

	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

	state_t              state_q;
	state_t              state_d;
	logic                side_q;
	logic [STEP_W-1:0]   cnt_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (sample_valid && sample_last) begin
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: state_d = ST_MUL;
			ST_MUL:   state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == LAST_STEP) begin
					state_d = ST_STORE;
				end
			end
			ST_STORE: state_d = (side_q == SIDE_BACK) ? ST_LOAD : ST_SETUP;
			ST_LOAD: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			side_q  <= SIDE_FRONT;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (state_q == ST_IDLE) begin
				side_q <= SIDE_FRONT;
			end else if (state_q == ST_STORE) begin
				side_q <= SIDE_BACK;
			end
		end
	end

	always_comb begin
		sample_ready = (state_q == ST_IDLE);
		cmd.fold     = sample_ready && sample_valid;
		cmd.setup    = (state_q == ST_SETUP);
		cmd.mul      = (state_q == ST_MUL);
		cmd.div_step = (state_q == ST_DIV);
		cmd.store    = (state_q == ST_STORE);
		cmd.load_out = (state_q == ST_LOAD) && status.out_free;
		cmd.side     = side_q;
	end

	// An end-of-scan sample always starts the decision with the front side.
	a_last_starts_front: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && sample_valid && sample_last)
		|=> (state_q == ST_SETUP && side_q == SIDE_FRONT))
		else $error("end of scan did not start the front decision");

	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q == LAST_STEP) |=> (state_q == ST_STORE))
		else $error("divider ran a wrong number of steps");

	a_front_then_back: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STORE && side_q == SIDE_FRONT)
		|=> (state_q == ST_SETUP && side_q == SIDE_BACK))
		else $error("back side decision did not follow the front side");

	a_load_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> (state_q == ST_IDLE && !cmd.setup))
		else $error("controller did not return to idle after the result load");

endmodule
`default_nettype wire

// ===== sv/sspf_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sspf_dp
	import sspf_pkg::*;
#(
	parameter int SCAN_POINTS = 360,
	parameter int RANGE_BITS  = 16
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  dp_cmd_t               cmd,
	output dp_status_t            status,
	input  wire                   cfg_we,
	input  wire [CFG_IDX_W-1:0]   cfg_index,
	input  wire [CFG_DATA_W-1:0]  cfg_data,
	input  wire [RANGE_W-1:0]     sample_range,
	input  wire [ANGLE_W-1:0]     sample_angle,
	output logic                  out_valid,
	input  wire                   out_ready,
	output logic                  out_fwd_rumble,
	output logic [FORCE_W-1:0]    out_fwd_intensity,
	output logic                  out_bwd_rumble,
	output logic [FORCE_W-1:0]    out_bwd_intensity
);

	localparam int CW = (RANGE_BITS > LIMIT_W) ? RANGE_BITS : LIMIT_W;
	localparam int SPW = $clog2(SCAN_POINTS + 1);
	localparam int AW = (SPW > ANGLE_W) ? SPW : ANGLE_W;
	localparam logic [AW-1:0] NPTS   = AW'(SCAN_POINTS);
	localparam logic [AW-1:0] CENTRE = AW'(SCAN_POINTS / 2);

	// Configuration registers.
	logic [LIMIT_W-1:0] near_q;
	logic [LIMIT_W-1:0] side_lim_q;
	logic [LIMIT_W-1:0] min_range_q;
	logic [HALF_W-1:0]  narrow_q;
	logic [HALF_W-1:0]  wide_q;
	logic [FORCE_W-1:0] force_q;

	logic [RANGE_BITS-1:0] fn_min_q;
	logic [RANGE_BITS-1:0] fw_min_q;
	logic [RANGE_BITS-1:0] bn_min_q;
	logic [RANGE_BITS-1:0] bw_min_q;

	logic               rumble_q;
	logic               sat_q;
	logic [LIMIT_W-1:0] diff_q;
	logic [LIMIT_W-1:0] span_q;
	logic [LIMIT_W-1:0] rem_q;
	logic [FORCE_W-1:0] quo_q;

	logic               fwd_rumble_q;
	logic [FORCE_W-1:0] fwd_int_q;
	logic               bwd_rumble_q;
	logic [FORCE_W-1:0] bwd_int_q;
	logic               out_valid_q;

	// Sector membership of the incoming sample.
	logic [AW-1:0]         idx;
	logic [AW-1:0]         df;
	logic [AW-1:0]         wrap;
	logic [AW-1:0]         db;
	logic                  in_scan;
	logic                  in_fn;
	logic                  in_fw;
	logic                  in_bn;
	logic                  in_bw;
	logic [RANGE_BITS-1:0] rng;

	always_comb begin
		idx     = AW'(sample_angle);
		in_scan = idx < NPTS;
		df      = (idx >= CENTRE) ? (idx - CENTRE) : (CENTRE - idx);
		wrap    = NPTS - idx;
		db      = (idx < wrap) ? idx : wrap;
		in_fn   = in_scan && (df <= AW'(narrow_q));
		in_fw   = in_scan && (df <= AW'(wide_q));
		in_bn   = in_scan && (db <= AW'(narrow_q));
		in_bw   = in_scan && (db <= AW'(wide_q));
		rng     = RANGE_BITS'(CW'(sample_range));
	end

	// Per-side decision inputs.
	logic [RANGE_BITS-1:0] nmin;
	logic [RANGE_BITS-1:0] wmin;
	logic                  near_hit;
	logic                  wide_hit;
	logic [LIMIT_W-1:0]    limit;
	logic [LIMIT_W-1:0]    min_lo;
	logic [LIMIT_W-1:0]    diff;
	logic [LIMIT_W-1:0]    span;
	logic                  sat;

	always_comb begin
		nmin     = (cmd.side == SIDE_BACK) ? bn_min_q : fn_min_q;
		wmin     = (cmd.side == SIDE_BACK) ? bw_min_q : fw_min_q;
		near_hit = CW'(nmin) < CW'(near_q);
		wide_hit = CW'(wmin) < CW'(side_lim_q);
		limit    = near_hit ? near_q : side_lim_q;
		// A hit minimum lies below a 16-bit limit, so its low bits hold it whole.
		min_lo   = near_hit ? LIMIT_W'(CW'(nmin)) : LIMIT_W'(CW'(wmin));
		diff     = limit - min_lo;
		span     = limit - min_range_q;
		// When the difference reaches the span the quotient is at least force_max.
		sat      = (limit <= min_range_q) || (diff >= span);
	end

	// Product and restoring division step.
	logic [PROD_W-1:0]  prod;
	logic [LIMIT_W:0]   trial;
	logic               qbit;
	logic [FORCE_W-1:0] intensity;

	always_comb begin
		prod      = PROD_W'(diff_q) * PROD_W'(force_q);
		trial     = {rem_q, quo_q[FORCE_W-1]} - {1'b0, span_q};
		qbit      = !trial[LIMIT_W];
		intensity = !rumble_q ? '0 : (sat_q ? force_q : quo_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q      <= NEAR_LIMIT_RST;
			side_lim_q  <= SIDE_LIMIT_RST;
			min_range_q <= MIN_RANGE_RST;
			narrow_q    <= NARROW_HALF_RST;
			wide_q      <= WIDE_HALF_RST;
			force_q     <= FORCE_MAX_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NEAR_LIMIT:  near_q      <= cfg_data[LIMIT_W-1:0];
				CFG_SIDE_LIMIT:  side_lim_q  <= cfg_data[LIMIT_W-1:0];
				CFG_MIN_RANGE:   min_range_q <= cfg_data[LIMIT_W-1:0];
				CFG_NARROW_HALF: narrow_q    <= cfg_data[HALF_W-1:0];
				CFG_WIDE_HALF:   wide_q      <= cfg_data[HALF_W-1:0];
				CFG_FORCE_MAX:   force_q     <= cfg_data[FORCE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fn_min_q <= '1;
			fw_min_q <= '1;
			bn_min_q <= '1;
			bw_min_q <= '1;
		end else if (cmd.load_out) begin
			fn_min_q <= '1;
			fw_min_q <= '1;
			bn_min_q <= '1;
			bw_min_q <= '1;
		end else if (cmd.fold) begin
			if (in_fn && rng < fn_min_q) begin
				fn_min_q <= rng;
			end
			if (in_fw && rng < fw_min_q) begin
				fw_min_q <= rng;
			end
			if (in_bn && rng < bn_min_q) begin
				bn_min_q <= rng;
			end
			if (in_bw && rng < bw_min_q) begin
				bw_min_q <= rng;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			rumble_q <= near_hit || wide_hit;
			sat_q    <= sat;
			diff_q   <= diff;
			span_q   <= span;
		end
		if (cmd.mul) begin
			// Unsaturated quotients stay below 1024, so the top bits start below the span.
			rem_q <= prod[PROD_W-1:FORCE_W];
			quo_q <= prod[FORCE_W-1:0];
		end else if (cmd.div_step) begin
			rem_q <= qbit ? trial[LIMIT_W-1:0] : {rem_q[LIMIT_W-2:0], quo_q[FORCE_W-1]};
			quo_q <= {quo_q[FORCE_W-2:0], qbit};
		end
		if (cmd.store) begin
			if (cmd.side == SIDE_BACK) begin
				bwd_rumble_q <= rumble_q;
				bwd_int_q    <= intensity;
			end else begin
				fwd_rumble_q <= rumble_q;
				fwd_int_q    <= intensity;
			end
		end
		if (cmd.load_out) begin
			out_fwd_rumble    <= fwd_rumble_q;
			out_fwd_intensity <= fwd_int_q;
			out_bwd_rumble    <= bwd_rumble_q;
			out_bwd_intensity <= bwd_int_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid       = out_valid_q;
	assign status.out_free = !out_valid_q || out_ready;

endmodule
`default_nettype wire

// ===== sv/scan_sector_proximity_feedback.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Lidar proximity feedback: samples enter on the samples channel and are folded into four
// running sector minimums (narrow and wide, around the front at half the scan and around the
// back through index 0). A sample without the end-of-scan mark leaves the input ready. The
// sample that ends a scan yields one feedback transaction and holds the input off until the
// result is loaded into the output register, which waits while an earlier transaction still
// sits on the feedback channel; each side takes a decision step, a multiply step, one step of the
// shared restoring divider per quotient bit and a store step, then the output register loads.
// Configuration writes go through cfg_we, cfg_index and cfg_data and are meant for idle
// periods only.
module scan_sector_proximity_feedback
	import sspf_pkg::*;
#(
	parameter int SCAN_POINTS = 360,
	parameter int RANGE_BITS  = 16
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_we,
	input  wire [CFG_IDX_W-1:0]  cfg_index,
	input  wire [CFG_DATA_W-1:0] cfg_data,
	sspf_sample_if.sink          samples,
	sspf_feedback_if.source      feedback
);

	dp_cmd_t    cmd;
	dp_status_t status;
	logic       sample_ready;

	sspf_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (samples.valid),
		.sample_last  (samples.last_of_scan),
		.status       (status),
		.sample_ready (sample_ready),
		.cmd          (cmd)
	);

	sspf_dp #(
		.SCAN_POINTS (SCAN_POINTS),
		.RANGE_BITS  (RANGE_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.sample_range      (samples.range_mm),
		.sample_angle      (samples.angle_index),
		.out_valid         (feedback.valid),
		.out_ready         (feedback.ready),
		.out_fwd_rumble    (feedback.forward_rumble),
		.out_fwd_intensity (feedback.forward_intensity),
		.out_bwd_rumble    (feedback.backward_rumble),
		.out_bwd_intensity (feedback.backward_intensity)
	);

	assign samples.ready = sample_ready;

endmodule
`default_nettype wire

// ===== sim/scan_sector_proximity_feedback_checker.sv =====
`timescale 1ns / 1ps
module scan_sector_proximity_feedback_checker
	import sspf_pkg::*;
#(
	parameter int SCAN_POINTS = 360,
	parameter int RANGE_BITS  = 16
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_we,
	input  wire [CFG_IDX_W-1:0]  cfg_index,
	input  wire [CFG_DATA_W-1:0] cfg_data,
	sspf_sample_if               samples,
	sspf_feedback_if             feedback,
	output int                   fail_count,
	output int                   due_count,
	output int                   sample_count,
	output int                   scan_count,
	output int                   rumble_count
);

	localparam int HALF_SCAN = SCAN_POINTS / 2;
	localparam logic [RANGE_W-1:0] RANGE_MASK =
		(RANGE_BITS >= RANGE_W) ? '1 : RANGE_W'((1 << RANGE_BITS) - 1);

	typedef struct packed {
		logic               fwd_rumble;
		logic [FORCE_W-1:0] fwd_intensity;
		logic               back_rumble;
		logic [FORCE_W-1:0] back_intensity;
	} feedback_t;

	logic [LIMIT_W-1:0] near_limit;
	logic [LIMIT_W-1:0] side_limit;
	logic [LIMIT_W-1:0] min_range;
	logic [HALF_W-1:0]  narrow_half;
	logic [HALF_W-1:0]  wide_half;
	logic [FORCE_W-1:0] force_ceiling;

	logic [RANGE_W-1:0] front_narrow_low;
	logic [RANGE_W-1:0] front_wide_low;
	logic [RANGE_W-1:0] back_narrow_low;
	logic [RANGE_W-1:0] back_wide_low;

	feedback_t feedback_due[$];
	feedback_t want;

	task automatic report_mismatch(input string msg);
		$display("%0t: feedback mismatch: %s", $time, msg);
		fail_count++;
	endtask

	function automatic void clear_sectors();
		front_narrow_low = RANGE_MASK;
		front_wide_low   = RANGE_MASK;
		back_narrow_low  = RANGE_MASK;
		back_wide_low    = RANGE_MASK;
	endfunction

	function automatic void fold_sample(input logic [RANGE_W-1:0] range_val,
		input logic [ANGLE_W-1:0] angle);
		int unsigned front_dist;
		int unsigned back_dist;
		logic [RANGE_W-1:0] r;
		r = range_val & RANGE_MASK;
		if (angle >= SCAN_POINTS)
			return;
		front_dist = (angle >= HALF_SCAN) ? angle - HALF_SCAN : HALF_SCAN - angle;
		back_dist = (angle < SCAN_POINTS - angle) ? angle : SCAN_POINTS - angle;
		if (front_dist <= narrow_half && r < front_narrow_low)
			front_narrow_low = r;
		if (front_dist <= wide_half && r < front_wide_low)
			front_wide_low = r;
		if (back_dist <= narrow_half && r < back_narrow_low)
			back_narrow_low = r;
		if (back_dist <= wide_half && r < back_wide_low)
			back_wide_low = r;
	endfunction

	// The caller guarantees that the minimum lies below the limit.
	function automatic logic [FORCE_W-1:0] proximity_intensity(input logic [LIMIT_W-1:0] limit,
		input logic [RANGE_W-1:0] minimum);
		logic [PROD_W-1:0] product;
		logic [PROD_W-1:0] quotient;
		if (limit <= min_range)
			return force_ceiling;
		product = PROD_W'(limit - minimum) * PROD_W'(force_ceiling);
		quotient = product / PROD_W'(limit - min_range);
		if (quotient > PROD_W'(force_ceiling))
			return force_ceiling;
		return quotient[FORCE_W-1:0];
	endfunction

	function automatic void judge_side(input logic [RANGE_W-1:0] narrow_low,
		input logic [RANGE_W-1:0] wide_low, output logic rumble,
		output logic [FORCE_W-1:0] intensity);
		if (narrow_low < near_limit) begin
			rumble = 1'b1;
			intensity = proximity_intensity(near_limit, narrow_low);
		end else if (wide_low < side_limit) begin
			rumble = 1'b1;
			intensity = proximity_intensity(side_limit, wide_low);
		end else begin
			rumble = 1'b0;
			intensity = '0;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_limit = NEAR_LIMIT_RST;
			side_limit = SIDE_LIMIT_RST;
			min_range = MIN_RANGE_RST;
			narrow_half = NARROW_HALF_RST;
			wide_half = WIDE_HALF_RST;
			force_ceiling = FORCE_MAX_RST;
			clear_sectors();
			feedback_due.delete();
			fail_count = 0;
			due_count = 0;
			sample_count = 0;
			scan_count = 0;
			rumble_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_NEAR_LIMIT: near_limit = cfg_data[LIMIT_W-1:0];
					CFG_SIDE_LIMIT: side_limit = cfg_data[LIMIT_W-1:0];
					CFG_MIN_RANGE: min_range = cfg_data[LIMIT_W-1:0];
					CFG_NARROW_HALF: narrow_half = cfg_data[HALF_W-1:0];
					CFG_WIDE_HALF: wide_half = cfg_data[HALF_W-1:0];
					CFG_FORCE_MAX: force_ceiling = cfg_data[FORCE_W-1:0];
					default: ;
				endcase
			end
			if (samples.valid && samples.ready) begin
				sample_count++;
				fold_sample(samples.range_mm, samples.angle_index);
				if (samples.last_of_scan) begin
					judge_side(front_narrow_low, front_wide_low, want.fwd_rumble,
						want.fwd_intensity);
					judge_side(back_narrow_low, back_wide_low, want.back_rumble,
						want.back_intensity);
					feedback_due.insert(feedback_due.size(), want);
					clear_sectors();
				end
			end
			if (feedback.valid && feedback.ready) begin
				if (feedback_due.size() == 0) begin
					report_mismatch("feedback transaction with nothing expected");
				end else begin
					want = feedback_due.pop_front();
					scan_count++;
					if (want.fwd_rumble || want.back_rumble)
						rumble_count++;
					if (feedback.forward_rumble !== want.fwd_rumble)
						report_mismatch($sformatf("scan %0d forward_rumble %b, expected %b",
							scan_count, feedback.forward_rumble, want.fwd_rumble));
					if (feedback.forward_intensity !== want.fwd_intensity)
						report_mismatch($sformatf("scan %0d forward_intensity %0d, expected %0d",
							scan_count, feedback.forward_intensity, want.fwd_intensity));
					if (feedback.backward_rumble !== want.back_rumble)
						report_mismatch($sformatf("scan %0d backward_rumble %b, expected %b",
							scan_count, feedback.backward_rumble, want.back_rumble));
					if (feedback.backward_intensity !== want.back_intensity)
						report_mismatch($sformatf("scan %0d backward_intensity %0d, expected %0d",
							scan_count, feedback.backward_intensity, want.back_intensity));
				end
			end
			due_count = feedback_due.size();
		end
	end

endmodule

// ===== sim/scan_sector_proximity_feedback_tb.sv =====
`timescale 1ns / 1ps
module scan_sector_proximity_feedback_tb;
	import sspf_pkg::*;

	localparam int SCAN_POINTS     = 360;
	localparam int RANGE_BITS      = 16;
	localparam int HALF_SCAN       = SCAN_POINTS / 2;
	localparam int HALF_PERIOD     = 5;
	localparam int HOLD_CYCLES     = 400;
	localparam int SETTLE_CYCLES   = 40;
	localparam int STALL_LIMIT     = 5000;
	localparam int ITEMS_PER_PHASE = 115;
	localparam int PHASES          = 7;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int fail_count;
	int due_count;
	int sample_count;
	int scan_count;
	int rumble_count;

	int src_idle_pct = 25;
	int sink_idle_pct = 25;
	bit hold_toggle = 1'b0;
	int stall_cycles = 0;
	int phase_items;

	int unsigned cur_near = NEAR_LIMIT_RST;
	int unsigned cur_side = SIDE_LIMIT_RST;
	int unsigned cur_minr = MIN_RANGE_RST;
	int unsigned cur_wide = WIDE_HALF_RST;

	sspf_sample_if   samples_ch();
	sspf_feedback_if feedback_ch();

	scan_sector_proximity_feedback #(
		.SCAN_POINTS(SCAN_POINTS),
		.RANGE_BITS(RANGE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.samples(samples_ch),
		.feedback(feedback_ch)
	);

	scan_sector_proximity_feedback_checker #(
		.SCAN_POINTS(SCAN_POINTS),
		.RANGE_BITS(RANGE_BITS)
	) checker_inst (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.samples(samples_ch),
		.feedback(feedback_ch),
		.fail_count(fail_count),
		.due_count(due_count),
		.sample_count(sample_count),
		.scan_count(scan_count),
		.rumble_count(rumble_count)
	);

	always #HALF_PERIOD clk = ~clk;

	// Feedback receiver: random back-pressure, plus a long hold-off on each request.
	initial begin
		int hold_left;
		bit hold_seen;
		hold_left = 0;
		hold_seen = 1'b0;
		feedback_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_toggle != hold_seen) begin
				hold_seen = hold_toggle;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				feedback_ch.ready <= 1'b0;
			end else begin
				feedback_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (samples_ch.valid && samples_ch.ready)
			|| (feedback_ch.valid && feedback_ch.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("stalled for %0d cycles with %0d feedback transactions outstanding",
				stall_cycles, due_count);
			$display("TB_ERROR");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic send_sample(input logic [RANGE_W-1:0] range_val,
		input logic [ANGLE_W-1:0] angle, input logic ends_scan);
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			samples_ch.valid <= 1'b0;
			@(negedge clk);
		end
		samples_ch.valid <= 1'b1;
		samples_ch.range_mm <= range_val;
		samples_ch.angle_index <= angle;
		samples_ch.last_of_scan <= ends_scan;
		@(posedge clk);
		while (!samples_ch.ready)
			@(posedge clk);
		phase_items++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_config(input int unsigned near_mm, input int unsigned side_mm,
		input int unsigned min_mm, input int unsigned narrow_hw, input int unsigned wide_hw,
		input int unsigned force_cap);
		write_reg(CFG_NEAR_LIMIT, CFG_DATA_W'(near_mm));
		write_reg(CFG_SIDE_LIMIT, CFG_DATA_W'(side_mm));
		write_reg(CFG_MIN_RANGE, CFG_DATA_W'(min_mm));
		write_reg(CFG_NARROW_HALF, CFG_DATA_W'(narrow_hw));
		write_reg(CFG_WIDE_HALF, CFG_DATA_W'(wide_hw));
		write_reg(CFG_FORCE_MAX, CFG_DATA_W'(force_cap));
		cur_near = near_mm;
		cur_side = side_mm;
		cur_minr = min_mm;
		cur_wide = wide_hw;
	endtask

	// Registers may only change once the block has gone quiet, so let every scan
	// drain and give a sample still being folded time to finish.
	task automatic drain_feedback();
		@(negedge clk);
		samples_ch.valid <= 1'b0;
		while (due_count != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [RANGE_W-1:0] pick_range();
		int unsigned roll;
		int unsigned ceiling;
		roll = $urandom_range(0, 99);
		ceiling = ((cur_near > cur_side) ? cur_near : cur_side) + 64;
		if (ceiling > 65535)
			ceiling = 65535;
		if (roll < 45)
			return RANGE_W'($urandom_range(0, ceiling));
		else if (roll < 55)
			return RANGE_W'($urandom_range(0, (cur_minr + 32 > 65535) ? 65535 : cur_minr + 32));
		else if (roll < 85)
			return RANGE_W'($urandom());
		else if (roll < 95)
			return '1;
		return '0;
	endfunction

	// Mostly aim at the sectors, with some anywhere and some past the end of the scan.
	function automatic logic [ANGLE_W-1:0] pick_angle();
		int unsigned roll;
		int unsigned reach;
		int unsigned offset;
		roll = $urandom_range(0, 99);
		reach = (cur_wide + 3 > HALF_SCAN) ? HALF_SCAN : cur_wide + 3;
		offset = $urandom_range(0, reach);
		if (roll < 35)
			return ANGLE_W'($urandom_range(0, 1) ? HALF_SCAN + offset : HALF_SCAN - offset);
		else if (roll < 70)
			return ANGLE_W'((offset == 0 || $urandom_range(0, 1)) ? offset : SCAN_POINTS - offset);
		else if (roll < 90)
			return ANGLE_W'($urandom_range(0, SCAN_POINTS - 1));
		return ANGLE_W'($urandom_range(SCAN_POINTS, (1 << ANGLE_W) - 1));
	endfunction

	task automatic send_random_scan(input int unsigned max_len);
		int unsigned len;
		len = $urandom_range(1, max_len);
		for (int i = 0; i < len; i++)
			send_sample(pick_range(), pick_angle(), i == len - 1);
	endtask

	initial begin
		samples_ch.valid = 1'b0;
		samples_ch.range_mm = '0;
		samples_ch.angle_index = '0;
		samples_ch.last_of_scan = 1'b0;
		phase_items = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed scans at the reset settings: sector edges, out-of-scan samples,
		// empty sectors, the wrap through index zero and the side-limit fallback.
		send_sample(16'd0, 9'd180, 1'b0);
		send_sample(16'hFFFF, 9'd0, 1'b0);
		send_sample(16'd100, 9'd359, 1'b0);
		send_sample(16'd0, 9'd360, 1'b1);
		send_sample(16'd499, 9'd170, 1'b0);
		send_sample(16'd349, 9'd145, 1'b0);
		send_sample(16'd1, 9'd10, 1'b0);
		send_sample(16'd200, 9'd325, 1'b0);
		send_sample(16'd0, 9'd511, 1'b1);
		send_sample(16'hFFFF, 9'd190, 1'b1);
		send_sample(16'd500, 9'd171, 1'b0);
		send_sample(16'd350, 9'd146, 1'b0);
		send_sample(16'd349, 9'd11, 1'b0);
		send_sample(16'h5555, 9'd256, 1'b1);
		send_sample(16'd0, 9'd0, 1'b1);
		send_sample(16'hAAAA, 9'd181, 1'b1);

		for (int p = 0; p < PHASES; p++) begin
			drain_feedback();
			case (p)
				0: begin
					// One complete ordered sweep at the reset settings.
					for (int i = 0; i < SCAN_POINTS; i++)
						send_sample(pick_range(), ANGLE_W'(i), i == SCAN_POINTS - 1);
				end
				1: begin
					write_reg(CFG_SPARE_LO, '1);
					write_reg(CFG_SPARE_HI, '0);
					apply_config(65535, 0, 0, 0, 179, 1023);
				end
				2: apply_config(0, 65535, 65535, 179, 0, 0);
				3: apply_config(800, 600, 200, 5, 40, 777);
				4: apply_config(1, 1, 0, 76, 100, 1);
				5: apply_config($urandom_range(0, 3000), $urandom_range(0, 3000),
					$urandom_range(0, 1500), $urandom_range(0, 179), $urandom_range(0, 179),
					$urandom_range(0, 1023));
				default: apply_config($urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 2000), $urandom_range(0, 179), $urandom_range(0, 179),
					$urandom_range(0, 1023));
			endcase
			src_idle_pct = (p == 1) ? 0 : 25;
			sink_idle_pct = (p == 1) ? 0 : 25;
			phase_items = 0;
			while (phase_items < ITEMS_PER_PHASE) begin
				if (p == 3 && phase_items >= 40 && phase_items < 60) begin
					// Hold the feedback channel off while short scans keep arriving,
					// so the block fills up and back-pressures the samples.
					hold_toggle = ~hold_toggle;
					src_idle_pct = 0;
					repeat (12) send_random_scan(2);
					src_idle_pct = 25;
				end else begin
					send_random_scan(24);
				end
			end
		end

		drain_feedback();
		$display("Covered %0d samples and %0d feedback transactions (%0d with rumble)",
			sample_count, scan_count, rumble_count);
		$display("across %0d register settings, including a long feedback hold-off",
			PHASES);
		if (fail_count == 0 && due_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== scan_sector_proximity_feedback.f =====
sv/sspf_pkg.sv
sv/sspf_sample_if.sv
sv/sspf_feedback_if.sv
sv/sspf_ctrl.sv
sv/sspf_dp.sv
sv/scan_sector_proximity_feedback.sv
sim/scan_sector_proximity_feedback_checker.sv
sim/scan_sector_proximity_feedback_tb.sv
